// ===== rtl/core/bcs_pkg.sv =====
// Package: shared types, calendar tables and helper functions for the BCD calendar converter.
`default_nettype none
package bcs_pkg;

  localparam int unsigned DaysW  = 16;  // days since epoch, at most 36524
  localparam int unsigned HoursW = 20;  // hours since epoch
  localparam int unsigned MinsW  = 26;  // minutes since epoch
  localparam int unsigned SecsW  = 32;  // seconds since epoch
  localparam int unsigned NumStages = 4;

  localparam logic [7:0] CtrlBadMask = 8'hc0;

  // Decoded and checked calendar, handed from the front-end stage.
  typedef struct packed {
    logic              ok;
    logic [DaysW-1:0]  days;
    logic [4:0]        hr;
    logic [5:0]        mn;
    logic [5:0]        sc;
    logic [6:0]        sec_bcd;
    logic [6:0]        min_bcd;
  } bcs_dec_t;

  // Length of a month (1..12); codes outside that range mean nothing.
  function automatic logic [4:0] month_len(input logic [4:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      5'd2:    len = leap ? 5'd29 : 5'd28;
      5'd4:    len = 5'd30;
      5'd6:    len = 5'd30;
      5'd9:    len = 5'd30;
      5'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Days in the year before the first of month m.
  function automatic logic [8:0] days_before(input logic [4:0] m, input logic leap);
    logic [8:0] base;
    case (m)
      5'd1:    base = 9'd0;
      5'd2:    base = 9'd31;
      5'd3:    base = 9'd59;
      5'd4:    base = 9'd90;
      5'd5:    base = 9'd120;
      5'd6:    base = 9'd151;
      5'd7:    base = 9'd181;
      5'd8:    base = 9'd212;
      5'd9:    base = 9'd243;
      5'd10:   base = 9'd273;
      5'd11:   base = 9'd304;
      5'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + {8'd0, (leap && (m > 5'd2))};
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/bcd_calendar_to_seconds_unit.sv =====
// Top level: four-stage pipeline converting a BCD calendar snapshot to seconds since 2000.
// An accepted item passes stage registers s1..s4 in turn to the output; stalls can hold it.
// Throughput: one item per cycle when not stalled; stages 2-4 scale by a constant and add.
// Stages: decode and day count, days*24+h, hours*60+m, minutes*60+s with zeroing.
// Reset: rst_ni clears the stage valid bits only; payload registers are not reset.
// Per-stage enables let bubbles collapse, so input is stalled only when all stages are full.
`default_nettype none
module bcd_calendar_to_seconds_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  control_byte_i,
  input  logic [7:0]  raw_seconds_i,
  input  logic [7:0]  raw_minutes_i,
  input  logic [7:0]  raw_hours_i,
  input  logic [7:0]  raw_date_i,
  input  logic [7:0]  raw_month_i,
  input  logic [7:0]  raw_year_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        valid_res_o,
  output logic [31:0] total_seconds_o,
  output logic [6:0]  masked_seconds_bcd_o,
  output logic [6:0]  masked_minutes_bcd_o
);
  import bcs_pkg::*;

  // Stage valid bits travel alongside the data.
  logic [NumStages-1:0] vld_q, vld_d;
  logic [NumStages-1:0] en;

  bcs_dec_t dec;

  // Stage 1: decoded calendar.
  bcs_dec_t s1_q;
  // Stage 2: hours since epoch.
  logic              s2_ok_q;
  logic [HoursW-1:0] s2_hours_q;
  logic [5:0]        s2_mn_q, s2_sc_q;
  logic [6:0]        s2_sec_bcd_q, s2_min_bcd_q;
  // Stage 3: minutes since epoch.
  logic              s3_ok_q;
  logic [MinsW-1:0]  s3_mins_q;
  logic [5:0]        s3_sc_q;
  logic [6:0]        s3_sec_bcd_q, s3_min_bcd_q;
  // Stage 4: output register.
  logic              s4_ok_q;
  logic [SecsW-1:0]  s4_secs_q;
  logic [6:0]        s4_sec_bcd_q, s4_min_bcd_q;

  logic [HoursW-1:0] hours_d;
  logic [MinsW-1:0]  mins_d;
  logic [SecsW-1:0]  secs_d;

  bcs_decode u_decode (
    .control_byte_i (control_byte_i),
    .raw_seconds_i  (raw_seconds_i),
    .raw_minutes_i  (raw_minutes_i),
    .raw_hours_i    (raw_hours_i),
    .raw_date_i     (raw_date_i),
    .raw_month_i    (raw_month_i),
    .raw_year_i     (raw_year_i),
    .dec_o          (dec)
  );

  // A stage may load when it is empty or the stage after it moves on.
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[0];

  always_comb begin
    vld_d[0] = en[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Each stage scales by one constant and adds the next finer unit.
  assign hours_d = HoursW'(s1_q.days) * HoursW'(24) + HoursW'(s1_q.hr);
  assign mins_d  = MinsW'(s2_hours_q) * MinsW'(60) + MinsW'(s2_mn_q);
  assign secs_d  = SecsW'(s3_mins_q) * SecsW'(60) + SecsW'(s3_sc_q);

  // Hold payload while stalled; advance on enable.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_q <= dec;
    end
    if (en[1]) begin
      s2_ok_q      <= s1_q.ok;
      s2_hours_q   <= hours_d;
      s2_mn_q      <= s1_q.mn;
      s2_sc_q      <= s1_q.sc;
      s2_sec_bcd_q <= s1_q.sec_bcd;
      s2_min_bcd_q <= s1_q.min_bcd;
    end
    if (en[2]) begin
      s3_ok_q      <= s2_ok_q;
      s3_mins_q    <= mins_d;
      s3_sc_q      <= s2_sc_q;
      s3_sec_bcd_q <= s2_sec_bcd_q;
      s3_min_bcd_q <= s2_min_bcd_q;
    end
    if (en[3]) begin
      // Drop every field of a rejected item to zero.
      s4_ok_q      <= s3_ok_q;
      s4_secs_q    <= s3_ok_q ? secs_d : '0;
      s4_sec_bcd_q <= s3_ok_q ? s3_sec_bcd_q : '0;
      s4_min_bcd_q <= s3_ok_q ? s3_min_bcd_q : '0;
    end
  end

  assign out_valid_o          = vld_q[NumStages-1];
  assign valid_res_o          = s4_ok_q;
  assign total_seconds_o      = s4_secs_q;
  assign masked_seconds_bcd_o = s4_sec_bcd_q;
  assign masked_minutes_bcd_o = s4_min_bcd_q;

  // Input stalls only when every stage holds an item.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (vld_q == '1))
    else $error("input stalled with an empty stage");

  // A rejected result carries all-zero fields.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !valid_res_o) |->
      (total_seconds_o == '0 && masked_seconds_bcd_o == '0 && masked_minutes_bcd_o == '0))
    else $error("rejected item has nonzero fields");

  // An accepted result stays within the 2000..2099 span.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && valid_res_o) |-> (total_seconds_o <= 32'd3155759999))
    else $error("seconds count out of range");

  // A stage that was full and blocked still holds its item next cycle.
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && !en[1]) |=> vld_q[1])
    else $error("stage item lost during stall");

endmodule
`default_nettype wire

// ===== rtl/core/bcs_decode.sv =====
// Front end: mask the BCD bytes, check digits and ranges, and count days since epoch.
`default_nettype none
module bcs_decode (
  input  logic [7:0]       control_byte_i,
  input  logic [7:0]       raw_seconds_i,
  input  logic [7:0]       raw_minutes_i,
  input  logic [7:0]       raw_hours_i,
  input  logic [7:0]       raw_date_i,
  input  logic [7:0]       raw_month_i,
  input  logic [7:0]       raw_year_i,
  output bcs_pkg::bcs_dec_t dec_o
);
  import bcs_pkg::*;

  logic [6:0] sec_b, min_b;
  logic [5:0] hr_b, date_b;
  logic [4:0] mon_b;
  logic       digits_ok;
  logic [6:0] sec_v, min_v;
  logic [5:0] hr_v, date_v;
  logic [4:0] mon_v;
  logic [7:0] yr_v;
  logic       leap;
  logic       range_ok;
  logic [16:0] yr_days;
  logic [16:0] days_sum;

  assign sec_b  = raw_seconds_i[6:0];
  assign min_b  = raw_minutes_i[6:0];
  assign hr_b   = raw_hours_i[5:0];
  assign date_b = raw_date_i[5:0];
  assign mon_b  = raw_month_i[4:0];

  // High nibbles of the 7-bit and narrower bytes cannot exceed 9.
  assign digits_ok = (sec_b[3:0] <= 4'd9) && (min_b[3:0] <= 4'd9) &&
                     (hr_b[3:0] <= 4'd9) && (date_b[3:0] <= 4'd9) &&
                     (mon_b[3:0] <= 4'd9) && (raw_year_i[3:0] <= 4'd9) &&
                     (raw_year_i[7:4] <= 4'd9);

  assign sec_v  = {4'd0, sec_b[6:4]} * 7'd10 + {3'd0, sec_b[3:0]};
  assign min_v  = {4'd0, min_b[6:4]} * 7'd10 + {3'd0, min_b[3:0]};
  assign hr_v   = {4'd0, hr_b[5:4]} * 6'd10 + {2'd0, hr_b[3:0]};
  assign date_v = {4'd0, date_b[5:4]} * 6'd10 + {2'd0, date_b[3:0]};
  assign mon_v  = (mon_b[4] ? 5'd10 : 5'd0) + {1'b0, mon_b[3:0]};
  assign yr_v   = {4'd0, raw_year_i[7:4]} * 8'd10 + {4'd0, raw_year_i[3:0]};

  assign leap = (yr_v[1:0] == 2'd0);

  assign range_ok = (sec_v <= 7'd59) && (min_v <= 7'd59) && (hr_v <= 6'd23) &&
                    (mon_v != 5'd0) && (mon_v <= 5'd12) && (date_v != 6'd0) &&
                    (date_v <= {1'b0, month_len(mon_v, leap)});

  // Leap days before this year: one per started group of four, year 00 included.
  assign yr_days  = 17'(yr_v) * 17'd365 + 17'(({1'b0, yr_v} + 9'd3) >> 2);
  assign days_sum = yr_days + {8'd0, days_before(mon_v, leap)} + {11'd0, date_v} - 17'd1;

  always_comb begin
    dec_o.ok      = ((control_byte_i & CtrlBadMask) == 8'd0) && digits_ok && range_ok;
    dec_o.days    = days_sum[DaysW-1:0];
    dec_o.hr      = hr_v[4:0];
    dec_o.mn      = min_v[5:0];
    dec_o.sc      = sec_v[5:0];
    dec_o.sec_bcd = sec_b;
    dec_o.min_bcd = min_b;
  end

endmodule
`default_nettype wire
